>>> src/mtes_pkg.sv
// Shared types, codes and widths for the one-shot timer scheduler.
package mtes_pkg;

   // Fixed field widths of the request and response transactions
   localparam int REQ_W  = 2;
   localparam int ID_W   = 4;
   localparam int LEN_W  = 24;
   localparam int KIND_W = 2;

   // Default sizing of the timer table and the millisecond counter
   localparam int DEF_NUM_TIMERS = 16;
   localparam int DEF_TIME_BITS  = 32;

   // Request codes
   typedef enum logic [REQ_W-1:0] {
      REQ_TICK    = 2'd0,
      REQ_ADD     = 2'd1,
      REQ_RESTART = 2'd2,
      REQ_REMOVE  = 2'd3
   } req_code_type;

   // Response event codes
   typedef enum logic [KIND_W-1:0] {
      KIND_FIRED     = 2'd0,
      KIND_DONE      = 2'd1,
      KIND_NOT_FOUND = 2'd2
   } kind_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic accept;      // capture request id
      logic add_wr;      // arm timer from request fields
      logic tick_start;  // advance counter, restart scan
      logic scan_rd;     // read deadline at scan index, advance
      logic scan_rst;    // rewind scan index for emission
      logic emit_step;   // emit current mask entry if set, advance
      logic len_rd;      // read stored length of captured id
      logic restart_wr;  // rewrite deadline from stored length
      logic answer;      // load command answer into output register
      logic drop;        // disarm captured id if armed
   } ctl_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic scan_end;    // scan index at last entry
      logic mask_hit;    // expiry mask set at scan index
      logic out_free;    // output register can take a transaction
   } dp_status_type;

endpackage

>>> src/mtes_ctrl.sv
// Controller state machine for the one-shot timer scheduler.
module mtes_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [1:0]             req_type,
   input  mtes_pkg::dp_status_type status,
   output mtes_pkg::ctl_cmd_type   cmd
);
   import mtes_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE       = 8'b0000_0001,
      ST_SCAN       = 8'b0000_0010,
      ST_DRAIN      = 8'b0000_0100,
      ST_EMIT       = 8'b0000_1000,
      ST_RS_READ    = 8'b0001_0000,
      ST_RS_WRITE   = 8'b0010_0000,
      ST_RS_ANSWER  = 8'b0100_0000,
      ST_RM_ANSWER  = 8'b1000_0000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Take a request only between operations
   assign req_stall = (state_ff != ST_IDLE);

   // Sequence each operation
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               case (req_type)
                  REQ_TICK: begin
                     cmd.tick_start = 1'b1;
                     state_in       = ST_SCAN;
                  end
                  REQ_ADD: begin
                     cmd.add_wr = 1'b1;
                  end
                  REQ_RESTART: begin
                     state_in = ST_RS_READ;
                  end
                  REQ_REMOVE: begin
                     state_in = ST_RM_ANSWER;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            cmd.scan_rd = 1'b1;
            if (status.scan_end) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            cmd.scan_rst = 1'b1;
            state_in     = ST_EMIT;
         end
         ST_EMIT: begin
            // Hold on a pending expiry while the output is occupied
            if (!status.mask_hit || status.out_free) begin
               cmd.emit_step = 1'b1;
               if (status.scan_end) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_RS_READ: begin
            cmd.len_rd = 1'b1;
            state_in   = ST_RS_WRITE;
         end
         ST_RS_WRITE: begin
            cmd.restart_wr = 1'b1;
            state_in       = ST_RS_ANSWER;
         end
         ST_RS_ANSWER: begin
            if (status.out_free) begin
               cmd.answer = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_RM_ANSWER: begin
            if (status.out_free) begin
               cmd.answer = 1'b1;
               cmd.drop   = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // A started scan always walks the table before the next request
   a_tick_enters_scan: assert property (@(posedge clock) disable iff (reset)
      cmd.tick_start |=> (state_ff == ST_SCAN))
      else $error("tick did not start a scan");

   // Answers are loaded only into a free output register
   a_answer_free: assert property (@(posedge clock) disable iff (reset)
      cmd.answer |-> status.out_free)
      else $error("answer loaded into a busy output");

   // Emission leaves only from the last table entry
   a_emit_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) && (state_in == ST_IDLE) |-> status.scan_end)
      else $error("emission ended early");

endmodule

>>> src/mtes_datapath.sv
// Datapath of the one-shot timer scheduler: counter, timer table, output register.
module mtes_datapath #(
   parameter int NUM_TIMERS = mtes_pkg::DEF_NUM_TIMERS,
   parameter int TIME_BITS  = mtes_pkg::DEF_TIME_BITS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [mtes_pkg::ID_W-1:0]   req_timer_id,
   input  logic [mtes_pkg::LEN_W-1:0]  req_delay_ms,
   input  mtes_pkg::ctl_cmd_type        cmd,
   output mtes_pkg::dp_status_type      status,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [mtes_pkg::ID_W-1:0]   rsp_timer_id_out,
   output logic [mtes_pkg::KIND_W-1:0] rsp_event_kind,
   output logic                        rsp_last
);
   import mtes_pkg::*;

   localparam int IDX_W = $clog2(NUM_TIMERS);
   localparam int SUM_W = (TIME_BITS > LEN_W) ? TIME_BITS : LEN_W;

   // Control registers
   logic [TIME_BITS-1:0]  now_ff,     now_in;
   logic [NUM_TIMERS-1:0] armed_ff,   armed_in;
   logic [NUM_TIMERS-1:0] mask_ff,    mask_in;
   logic [IDX_W-1:0]      idx_ff,     idx_in;
   logic                  cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]      cmp_idx_ff, cmp_idx_in;
   logic [ID_W-1:0]       id_ff,      id_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]       rsp_id_ff,    rsp_id_in;
   logic [KIND_W-1:0]     rsp_kind_ff,  rsp_kind_in;
   logic                  rsp_last_ff,  rsp_last_in;

   // Timer table storage
   logic [TIME_BITS-1:0] dl_mem  [NUM_TIMERS];
   logic [LEN_W-1:0]     len_mem [NUM_TIMERS];
   logic [TIME_BITS-1:0] dl_rd_ff;
   logic [LEN_W-1:0]     len_rd_ff;

   logic                 dl_we;
   logic [IDX_W-1:0]     dl_waddr;
   logic [TIME_BITS-1:0] dl_wdata;
   logic                 len_we;

   logic                  req_in_range;
   logic                  id_in_range;
   logic [IDX_W-1:0]      req_idx;
   logic [IDX_W-1:0]      id_idx;
   logic                  hit;
   logic [TIME_BITS-1:0]  diff;
   logic                  cmp_fire;
   logic                  mask_hit;
   logic [NUM_TIMERS-1:0] mask_rest;
   logic                  out_free;
   logic                  emit_load;

   // Decode addressed entries
   assign req_in_range = (32'(req_timer_id) < NUM_TIMERS);
   assign id_in_range  = (32'(id_ff) < NUM_TIMERS);
   assign req_idx      = IDX_W'(req_timer_id);
   assign id_idx       = IDX_W'(id_ff);
   assign hit          = id_in_range && armed_ff[id_idx];

   // Wrap-safe expiry test on the deadline read last cycle
   assign diff     = now_ff - dl_rd_ff;
   assign cmp_fire = cmp_vld_ff && armed_ff[cmp_idx_ff] && !diff[TIME_BITS-1];

   // Emission view of the expiry mask
   assign mask_hit = mask_ff[idx_ff];
   always_comb begin
      mask_rest         = mask_ff;
      mask_rest[idx_ff] = 1'b0;
   end

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign emit_load = cmd.emit_step && mask_hit;

   assign status.scan_end = (idx_ff == IDX_W'(NUM_TIMERS - 1));
   assign status.mask_hit = mask_hit;
   assign status.out_free = out_free;

   // Select the deadline write for add or restart
   always_comb begin
      dl_we    = 1'b0;
      dl_waddr = req_idx;
      dl_wdata = TIME_BITS'(SUM_W'(now_ff) + SUM_W'(req_delay_ms));
      len_we   = cmd.add_wr && req_in_range;
      if (cmd.add_wr && req_in_range) begin
         dl_we = 1'b1;
      end else if (cmd.restart_wr && hit) begin
         dl_we    = 1'b1;
         dl_waddr = id_idx;
         dl_wdata = TIME_BITS'(SUM_W'(now_ff) + SUM_W'(len_rd_ff));
      end
   end

   // Next state of counter, table flags and scan index
   always_comb begin
      now_in     = now_ff;
      armed_in   = armed_ff;
      mask_in    = mask_ff;
      idx_in     = idx_ff;
      cmp_vld_in = cmd.scan_rd;
      cmp_idx_in = idx_ff;
      id_in      = cmd.accept ? req_timer_id : id_ff;

      if (cmd.tick_start) begin
         now_in  = now_ff + TIME_BITS'(1);
         mask_in = '0;
      end
      if (cmd.add_wr && req_in_range) begin
         armed_in[req_idx] = 1'b1;
      end
      // Disarm and record each expired timer
      if (cmp_fire) begin
         armed_in[cmp_idx_ff] = 1'b0;
         mask_in[cmp_idx_ff]  = 1'b1;
      end
      if (cmd.drop && hit) begin
         armed_in[id_idx] = 1'b0;
      end
      if (emit_load) begin
         mask_in[idx_ff] = 1'b0;
      end

      if (cmd.tick_start || cmd.scan_rst) begin
         idx_in = '0;
      end else if (cmd.scan_rd || cmd.emit_step) begin
         idx_in = idx_ff + IDX_W'(1);
      end
   end

   // Load the output register with an expiry or a command answer
   always_comb begin
      rsp_id_in    = rsp_id_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (emit_load) begin
         rsp_valid_in = 1'b1;
         rsp_id_in    = ID_W'(idx_ff);
         rsp_kind_in  = KIND_FIRED;
         rsp_last_in  = ~|mask_rest;
      end else if (cmd.answer) begin
         rsp_valid_in = 1'b1;
         rsp_id_in    = id_ff;
         rsp_kind_in  = hit ? KIND_DONE : KIND_NOT_FOUND;
         rsp_last_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff       <= '0;
         armed_ff     <= '0;
         mask_ff      <= '0;
         idx_ff       <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         now_ff       <= now_in;
         armed_ff     <= armed_in;
         mask_ff      <= mask_in;
         idx_ff       <= idx_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmp_idx_ff  <= cmp_idx_in;
      id_ff       <= id_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_last_ff <= rsp_last_in;
   end

   // Write and read the timer table
   always_ff @(posedge clock) begin
      if (dl_we) begin
         dl_mem[dl_waddr] <= dl_wdata;
      end
      if (cmd.scan_rd) begin
         dl_rd_ff <= dl_mem[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (len_we) begin
         len_mem[req_idx] <= req_delay_ms;
      end
      if (cmd.len_rd) begin
         len_rd_ff <= len_mem[id_idx];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_timer_id_out = rsp_id_ff;
   assign rsp_event_kind   = rsp_kind_ff;
   assign rsp_last         = rsp_last_ff;

   // Every previous emission run drained the mask completely
   a_mask_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.tick_start |-> (mask_ff == '0))
      else $error("expiry mask not empty at tick");

   // An expired timer is disarmed as it is recorded
   a_fire_disarms: assert property (@(posedge clock) disable iff (reset)
      cmp_fire |=> !armed_ff[$past(cmp_idx_ff)])
      else $error("expired timer still armed");

   // The counter moves only on a tick
   a_now_stable: assert property (@(posedge clock) disable iff (reset)
      !cmd.tick_start |=> $stable(now_ff))
      else $error("counter moved without a tick");

   // Expiries are loaded only into a free output register
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      emit_load |-> out_free)
      else $error("expiry loaded into a busy output");

endmodule

>>> src/multi_timer_expiry_scheduler.sv
// Top level of the one-shot timer scheduler.
// Request channel (req_*): req_type selects tick, add, restart or remove;
// req_timer_id addresses a timer, req_delay_ms gives the add delay.
// Response channel (rsp_*): one transaction per fired timer or command answer;
// rsp_last marks the final response caused by a request.
// A tick advances the millisecond counter and scans all NUM_TIMERS entries:
// one deadline read per cycle from the table memory, then one entry per cycle
// through the expiry mask, except while an expiry waits on a stalled response.
// Add gives no response; remove goes straight to its answer, restart answers
// after a stored length read and a deadline rewrite. One request is in work
// at a time; req_stall is high from acceptance until the request's work ends:
// the whole emission walk for a tick, the answer load for restart or remove.
// Fired timers leave in ascending id order. A stalled response holds in the
// output register and the emission walk waits on the next expiry behind it.
// Reset clears the counter, all armed flags and the output valid flag; the
// deadline and length table needs no clearing pass.
module multi_timer_expiry_scheduler #(
   parameter int NUM_TIMERS = mtes_pkg::DEF_NUM_TIMERS,
   parameter int TIME_BITS  = mtes_pkg::DEF_TIME_BITS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [mtes_pkg::REQ_W-1:0]  req_type,
   input  logic [mtes_pkg::ID_W-1:0]   req_timer_id,
   input  logic [mtes_pkg::LEN_W-1:0]  req_delay_ms,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [mtes_pkg::ID_W-1:0]   rsp_timer_id_out,
   output logic [mtes_pkg::KIND_W-1:0] rsp_event_kind,
   output logic                        rsp_last
);
   import mtes_pkg::*;

   ctl_cmd_type   cmd;
   dp_status_type status;

   // Sequence requests
   mtes_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_type  (req_type),
      .status    (status),
      .cmd       (cmd)
   );

   // Hold the counter, timer table and output register
   mtes_datapath #(
      .NUM_TIMERS (NUM_TIMERS),
      .TIME_BITS  (TIME_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_timer_id     (req_timer_id),
      .req_delay_ms     (req_delay_ms),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_timer_id_out (rsp_timer_id_out),
      .rsp_event_kind   (rsp_event_kind),
      .rsp_last         (rsp_last)
   );

endmodule

>>> bench/multi_timer_expiry_scheduler_test.sv
// Self-checking testbench for the one-shot timer scheduler: directed table, then random traffic.
module multi_timer_expiry_scheduler_test;
   import mtes_pkg::*;

   localparam int NUM_TIMERS     = DEF_NUM_TIMERS;
   localparam int TIME_BITS      = DEF_TIME_BITS;
   localparam int RANDOM_ITEMS   = 300;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int DRAIN_CYCLES   = 3 * NUM_TIMERS;

   // How a directed row gets its expected response
   typedef enum logic [1:0] {
      CHK_PREDICT,   // computed by the timer table predictor
      CHK_SILENT,    // no response at all
      CHK_ANSWER     // one command answer, addressed id, last set
   } check_mode_type;

   typedef struct packed {
      req_code_type        op;
      logic [ID_W-1:0]     id;
      logic [LEN_W-1:0]    dly;
      check_mode_type      chk;
      kind_type            kind;
   } plan_row_type;

   typedef struct packed {
      logic [ID_W-1:0] id;
      kind_type        kind;
      logic            last;
   } timer_event_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [REQ_W-1:0]    req_type = '0;
   logic [ID_W-1:0]     req_timer_id = '0;
   logic [LEN_W-1:0]    req_delay_ms = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [ID_W-1:0]     rsp_timer_id_out;
   logic [KIND_W-1:0]   rsp_event_kind;
   logic                rsp_last;

   // Predictor copy of the timer table
   logic [TIME_BITS-1:0]  now_ms = '0;
   logic [NUM_TIMERS-1:0] armed_mask = '0;
   logic [TIME_BITS-1:0]  due_ms [NUM_TIMERS];
   logic [LEN_W-1:0]      length_ms [NUM_TIMERS];

   timer_event_type pending_events [$];
   int  mismatches = 0;
   int  idle_cycles = 0;
   bit  timed_out = 1'b0;
   int  burst_left = 0;
   int  random_sent = 0;
   int  stall_mode = 0;
   int  mode_left = 0;
   int  run_left = 0;

   plan_row_type plan [0:24] = '{
      '{REQ_TICK,    4'd0,  24'd0,        CHK_SILENT,  KIND_FIRED},
      '{REQ_RESTART, 4'd0,  24'd0,        CHK_ANSWER,  KIND_NOT_FOUND},
      '{REQ_REMOVE,  4'd15, 24'hFFFFFF,   CHK_ANSWER,  KIND_NOT_FOUND},
      '{REQ_ADD,     4'd0,  24'd0,        CHK_SILENT,  KIND_FIRED},
      '{REQ_ADD,     4'd15, 24'hFFFFFF,   CHK_SILENT,  KIND_FIRED},
      '{REQ_ADD,     4'd7,  24'd2,        CHK_SILENT,  KIND_FIRED},
      '{REQ_ADD,     4'd7,  24'd1,        CHK_SILENT,  KIND_FIRED},
      '{REQ_ADD,     4'd5,  24'd3,        CHK_SILENT,  KIND_FIRED},
      '{REQ_TICK,    4'd0,  24'd0,        CHK_PREDICT, KIND_FIRED},
      '{REQ_RESTART, 4'd15, 24'd0,        CHK_ANSWER,  KIND_DONE},
      '{REQ_REMOVE,  4'd15, 24'd0,        CHK_ANSWER,  KIND_DONE},
      '{REQ_REMOVE,  4'd15, 24'd0,        CHK_ANSWER,  KIND_NOT_FOUND},
      '{REQ_RESTART, 4'd0,  24'd0,        CHK_ANSWER,  KIND_NOT_FOUND},
      '{REQ_TICK,    4'd0,  24'd0,        CHK_PREDICT, KIND_FIRED},
      '{REQ_RESTART, 4'd5,  24'd0,        CHK_ANSWER,  KIND_DONE},
      '{REQ_TICK,    4'd0,  24'd0,        CHK_PREDICT, KIND_FIRED},
      '{REQ_TICK,    4'd0,  24'd0,        CHK_PREDICT, KIND_FIRED},
      '{REQ_TICK,    4'd0,  24'd0,        CHK_PREDICT, KIND_FIRED},
      '{REQ_ADD,     4'd10, 24'h800000,   CHK_SILENT,  KIND_FIRED},
      '{REQ_ADD,     4'd11, 24'h555555,   CHK_SILENT,  KIND_FIRED},
      '{REQ_ADD,     4'd12, 24'hAAAAAA,   CHK_SILENT,  KIND_FIRED},
      '{REQ_REMOVE,  4'd10, 24'd0,        CHK_ANSWER,  KIND_DONE},
      '{REQ_REMOVE,  4'd7,  24'd0,        CHK_ANSWER,  KIND_NOT_FOUND},
      '{REQ_ADD,     4'd1,  24'd1,        CHK_SILENT,  KIND_FIRED},
      '{REQ_TICK,    4'd0,  24'd0,        CHK_PREDICT, KIND_FIRED}
   };

   multi_timer_expiry_scheduler uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_timer_id     (req_timer_id),
      .req_delay_ms     (req_delay_ms),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_timer_id_out (rsp_timer_id_out),
      .rsp_event_kind   (rsp_event_kind),
      .rsp_last         (rsp_last)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Advance the timer table for one request and queue the responses it causes
   task automatic predict_timer_events(input req_code_type op, input logic [ID_W-1:0] id,
                                       input logic [LEN_W-1:0] dly, input bit keep);
      logic [TIME_BITS-1:0]  lag;
      logic [NUM_TIMERS-1:0] fire_set;
      kind_type              answer;
      fire_set = '0;
      case (op)
         REQ_TICK: begin
            now_ms = now_ms + 1'b1;
            for (int i = 0; i < NUM_TIMERS; i++) begin
               lag = now_ms - due_ms[i];
               if (armed_mask[i] && !lag[TIME_BITS-1])
                  fire_set[i] = 1'b1;
            end
            armed_mask = armed_mask & ~fire_set;
            for (int i = 0; i < NUM_TIMERS; i++) begin
               if (fire_set[i] && keep)
                  pending_events.push_back('{ID_W'(i), KIND_FIRED,
                                             (fire_set >> (i + 1)) == '0});
            end
         end
         REQ_ADD: begin
            if (id < NUM_TIMERS) begin
               armed_mask[id] = 1'b1;
               length_ms[id]  = dly;
               due_ms[id]     = now_ms + TIME_BITS'(dly);
            end
         end
         default: begin
            answer = KIND_NOT_FOUND;
            if (id < NUM_TIMERS && armed_mask[id]) begin
               answer = KIND_DONE;
               if (op == REQ_RESTART)
                  due_ms[id] = now_ms + TIME_BITS'(length_ms[id]);
               else
                  armed_mask[id] = 1'b0;
            end
            if (keep)
               pending_events.push_back('{id, answer, 1'b1});
         end
      endcase
   endtask

   // Drive one request in bursts with random gaps, hold it until accepted
   task automatic send_request(input req_code_type op, input logic [ID_W-1:0] id,
                               input logic [LEN_W-1:0] dly, input check_mode_type chk,
                               input kind_type kind);
      int gap;
      if (timed_out)
         return;
      @(negedge clock);
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (gap != 0) begin
            req_valid = 1'b0;
            repeat (gap - 1) @(negedge clock);
            @(negedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      req_valid    = 1'b1;
      req_type     = op;
      req_timer_id = id;
      req_delay_ms = dly;
      do
         @(posedge clock);
      while (req_stall && !timed_out);
      if (timed_out)
         return;
      predict_timer_events(op, id, dly, chk == CHK_PREDICT);
      if (chk == CHK_ANSWER)
         pending_events.push_back('{id, kind, 1'b1});
   endtask

   // Stall the response side in runs whose shape changes from time to time
   always @(negedge clock) begin
      if (mode_left == 0) begin
         stall_mode = $urandom_range(0, 2);
         mode_left  = $urandom_range(40, 400);
      end
      mode_left--;
      if (run_left == 0) begin
         case (stall_mode)
            0: begin
               rsp_stall = 1'b0;
               run_left  = $urandom_range(1, 20);
            end
            1: begin
               rsp_stall = 1'($urandom_range(0, 1));
               run_left  = $urandom_range(1, 3);
            end
            default: begin
               rsp_stall = !rsp_stall;
               run_left  = rsp_stall ? $urandom_range(4, 30) : $urandom_range(1, 2);
            end
         endcase
      end
      run_left--;
   end

   // Check each response transaction against the oldest expectation; watch for a hang
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_events.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected response id %0d kind %0d last %0d", $time,
                        rsp_timer_id_out, rsp_event_kind, rsp_last);
            end else begin
               if (rsp_timer_id_out != pending_events[0].id) begin
                  mismatches++;
                  $display("%0t: timer id expected %0d actual %0d", $time,
                           pending_events[0].id, rsp_timer_id_out);
               end
               if (rsp_event_kind != pending_events[0].kind) begin
                  mismatches++;
                  $display("%0t: event kind expected %0d actual %0d", $time,
                           pending_events[0].kind, rsp_event_kind);
               end
               if (rsp_last != pending_events[0].last) begin
                  mismatches++;
                  $display("%0t: last expected %0d actual %0d", $time,
                           pending_events[0].last, rsp_last);
               end
               void'(pending_events.pop_front());
            end
         end
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT)
            timed_out = 1'b1;
      end
   end

   initial begin
      int n;
      int d;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed table
      foreach (plan[r])
         send_request(plan[r].op, plan[r].id, plan[r].dly, plan[r].chk, plan[r].kind);

      // Random traffic, mostly well-formed arm-and-tick sequences
      while (random_sent < RANDOM_ITEMS && !timed_out) begin
         case ($urandom_range(0, 9))
            0: begin
               // arm the whole table with one delay, then tick until it all fires
               d = $urandom_range(0, 3);
               for (int k = 0; k < NUM_TIMERS; k++)
                  send_request(REQ_ADD, ID_W'(k), LEN_W'(d), CHK_PREDICT, KIND_FIRED);
               repeat (d + 1)
                  send_request(REQ_TICK, ID_W'($urandom()), LEN_W'($urandom()),
                               CHK_PREDICT, KIND_FIRED);
               random_sent += NUM_TIMERS + d + 1;
            end
            1, 2, 3, 4: begin
               // short timers, then ticks with commands mixed in
               n = $urandom_range(1, 5);
               repeat (n)
                  send_request(REQ_ADD, ID_W'($urandom_range(0, NUM_TIMERS - 1)),
                               LEN_W'($urandom_range(0, 8)), CHK_PREDICT, KIND_FIRED);
               random_sent += n;
               n = $urandom_range(1, 10);
               repeat (n) begin
                  if ($urandom_range(0, 2) == 0) begin
                     send_request($urandom_range(0, 1) ? REQ_RESTART : REQ_REMOVE,
                                  ID_W'($urandom_range(0, NUM_TIMERS - 1)),
                                  LEN_W'($urandom()), CHK_PREDICT, KIND_FIRED);
                     random_sent++;
                  end
                  send_request(REQ_TICK, ID_W'($urandom()), LEN_W'($urandom()),
                               CHK_PREDICT, KIND_FIRED);
                  random_sent++;
               end
            end
            5, 6: begin
               // commands on arbitrary ids, armed or not
               n = $urandom_range(1, 4);
               repeat (n)
                  send_request($urandom_range(0, 1) ? REQ_RESTART : REQ_REMOVE,
                               ID_W'($urandom_range(0, NUM_TIMERS - 1)),
                               LEN_W'($urandom()), CHK_PREDICT, KIND_FIRED);
               random_sent += n;
            end
            7: begin
               // long timer across the full delay range, then restart it
               n = $urandom_range(0, NUM_TIMERS - 1);
               send_request(REQ_ADD, ID_W'(n), LEN_W'($urandom()), CHK_PREDICT, KIND_FIRED);
               send_request(REQ_RESTART, ID_W'(n), LEN_W'($urandom()),
                            CHK_PREDICT, KIND_FIRED);
               random_sent += 2;
            end
            8: begin
               // ticks only
               n = $urandom_range(1, 6);
               repeat (n)
                  send_request(REQ_TICK, ID_W'($urandom()), LEN_W'($urandom()),
                               CHK_PREDICT, KIND_FIRED);
               random_sent += n;
            end
            default: begin
               // noise: any request with any fields
               send_request(req_code_type'($urandom_range(0, 3)), ID_W'($urandom()),
                            LEN_W'($urandom()), CHK_PREDICT, KIND_FIRED);
               random_sent++;
            end
         endcase
      end

      @(negedge clock);
      req_valid = 1'b0;

      // Drain outstanding responses, then let the block settle
      while (pending_events.size() != 0 && !timed_out)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (!timed_out && mismatches == 0 && pending_events.size() == 0)
         $display("multi_timer_expiry_scheduler regression: pass");
      else
         $display("multi_timer_expiry_scheduler regression: fail");
      $finish;
   end

endmodule

>>> files.f
src/mtes_pkg.sv
src/mtes_ctrl.sv
src/mtes_datapath.sv
src/multi_timer_expiry_scheduler.sv
bench/multi_timer_expiry_scheduler_test.sv
